### rtl/nmea_pkg.sv
// Shared types, constants and helpers for the NMEA position parser.
`timescale 1ns / 1ps

package nmea_pkg;

    // Widths fixed by the result fields.
    localparam int VALUE_W = 32;
    localparam int ACC_W   = 33;
    localparam int POW10_W = 20;

    // Characters the parser reacts to.
    localparam logic [7:0] CH_DOLLAR  = 8'h24;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_POINT   = 8'h2E;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_N       = 8'h4E;
    localparam logic [7:0] CH_S       = 8'h53;
    localparam logic [7:0] CH_E       = 8'h45;
    localparam logic [7:0] CH_W       = 8'h57;
    localparam logic [7:0] CH_G       = 8'h47;
    localparam logic [7:0] CH_M       = 8'h4D;
    localparam logic [7:0] CH_L       = 8'h4C;

    // Class of one received byte.
    typedef enum logic [2:0] {
        CLS_DOLLAR,
        CLS_NEWLINE,
        CLS_COMMA,
        CLS_DIGIT,
        CLS_POINT,
        CLS_OTHER
    } t_char_class;

    // Letter that may name the sentence type.
    typedef enum logic [1:0] {
        HINT_NONE,
        HINT_G,
        HINT_M,
        HINT_L
    } t_type_hint;

    // Classified byte as it travels through the queue.
    typedef struct packed {
        t_char_class cls;
        logic [3:0]  digit;
        t_type_hint  hint;
        logic        ns_mark;
        logic        south;
        logic        ew_mark;
        logic        west;
    } t_token;

    // Power of ten for a scale step of zero to six digits.
    function automatic logic [POW10_W-1:0] pow10(input logic [2:0] n);
        logic [POW10_W-1:0] v;
        case (n)
            3'd0:    v = POW10_W'(1);
            3'd1:    v = POW10_W'(10);
            3'd2:    v = POW10_W'(100);
            3'd3:    v = POW10_W'(1000);
            3'd4:    v = POW10_W'(10000);
            3'd5:    v = POW10_W'(100000);
            3'd6:    v = POW10_W'(1000000);
            default: v = POW10_W'(1);
        endcase
        return v;
    endfunction

endpackage

### rtl/nmea_front.sv
// Input stage: classify each received byte and push it into the queue.
`timescale 1ns / 1ps

module nmea_front
    import nmea_pkg::*;
(
    input  logic       i_valid,
    input  logic [7:0] i_rx_byte,
    input  logic       i_queue_full,
    output logic       o_ready,
    output logic       o_push,
    output t_token     o_token
);

    // Accept whenever the queue has room.
    assign o_ready = !i_queue_full;
    assign o_push  = i_valid && !i_queue_full;

    // Classify the byte.
    always_comb begin
        o_token.digit   = 4'(i_rx_byte - CH_ZERO);
        o_token.ns_mark = (i_rx_byte == CH_N) || (i_rx_byte == CH_S);
        o_token.south   = (i_rx_byte == CH_S);
        o_token.ew_mark = (i_rx_byte == CH_E) || (i_rx_byte == CH_W);
        o_token.west    = (i_rx_byte == CH_W);

        if (i_rx_byte == CH_DOLLAR) begin
            o_token.cls = CLS_DOLLAR;
        end else if (i_rx_byte == CH_NEWLINE) begin
            o_token.cls = CLS_NEWLINE;
        end else if (i_rx_byte == CH_COMMA) begin
            o_token.cls = CLS_COMMA;
        end else if (i_rx_byte == CH_POINT) begin
            o_token.cls = CLS_POINT;
        end else if (i_rx_byte inside {[CH_ZERO:CH_NINE]}) begin
            o_token.cls = CLS_DIGIT;
        end else begin
            o_token.cls = CLS_OTHER;
        end

        if (i_rx_byte == CH_G) begin
            o_token.hint = HINT_G;
        end else if (i_rx_byte == CH_M) begin
            o_token.hint = HINT_M;
        end else if (i_rx_byte == CH_L) begin
            o_token.hint = HINT_L;
        end else begin
            o_token.hint = HINT_NONE;
        end
    end

endmodule

### rtl/nmea_queue.sv
// Short FIFO of classified bytes between the input stage and the parser.
`timescale 1ns / 1ps

module nmea_queue
    import nmea_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_token i_token,
    input  logic   i_pop,
    output logic   o_full,
    output logic   o_not_empty,
    output t_token o_token
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_token             r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               do_push;
    logic               do_pop;

    assign o_full      = (r_count == CNT_W'(DEPTH));
    assign o_not_empty = (r_count != '0);
    assign o_token     = r_mem[r_rd_ptr];
    assign do_push     = i_push && !o_full;
    assign do_pop      = i_pop && o_not_empty;

    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    // Store entries.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_token;
        end
    end

    // Advance pointers and occupancy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= next_ptr(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= next_ptr(r_rd_ptr);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

### rtl/nmea_back.sv
// Parser: sentence framing, field conversion, position hold and result register.
`timescale 1ns / 1ps

module nmea_back
    import nmea_pkg::*;
#(
    parameter int MAX_SENTENCE_LEN = 80,
    parameter int MAX_FIELD_LEN    = 20,
    parameter int FRAC_DIGITS      = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_not_empty,
    input  t_token              i_token,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [1:0]          o_sentence_type,
    output logic [VALUE_W-1:0]  o_utc_time,
    output logic [VALUE_W-1:0]  o_latitude,
    output logic                o_south,
    output logic [VALUE_W-1:0]  o_longitude,
    output logic                o_west,
    output logic                o_position_updated
);

    localparam int POS_W  = $clog2(MAX_SENTENCE_LEN + 1);
    localparam int CHR_W  = $clog2(MAX_FIELD_LEN + 1);
    localparam int FRAC_W = $clog2(FRAC_DIGITS + 1);
    localparam int PROD_W = ACC_W + POW10_W;
    localparam int MUL_W  = ACC_W + 4;

    localparam logic [ACC_W-1:0]  ACC_SAT = {1'b1, {(ACC_W - 1){1'b0}}};
    localparam logic [MUL_W-1:0]  MUL_MAX = MUL_W'({VALUE_W{1'b1}});
    localparam logic [FRAC_W-1:0] FRAC_C  = FRAC_W'(FRAC_DIGITS);

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_GGA,
        KIND_RMC,
        KIND_GLL
    } t_kind;

    typedef enum logic [2:0] {
        ROLE_NONE,
        ROLE_TIME,
        ROLE_LAT,
        ROLE_NS,
        ROLE_LON,
        ROLE_EW
    } t_role;

    // Field layout of each sentence type.
    function automatic t_role role_of(input t_kind k, input logic [3:0] f);
        t_role r;
        r = ROLE_NONE;
        case (k)
            KIND_GGA: begin
                case (f)
                    4'd1:    r = ROLE_TIME;
                    4'd2:    r = ROLE_LAT;
                    4'd3:    r = ROLE_NS;
                    4'd4:    r = ROLE_LON;
                    4'd5:    r = ROLE_EW;
                    default: r = ROLE_NONE;
                endcase
            end
            KIND_RMC: begin
                case (f)
                    4'd1:    r = ROLE_TIME;
                    4'd3:    r = ROLE_LAT;
                    4'd4:    r = ROLE_NS;
                    4'd5:    r = ROLE_LON;
                    4'd6:    r = ROLE_EW;
                    default: r = ROLE_NONE;
                endcase
            end
            KIND_GLL: begin
                case (f)
                    4'd1:    r = ROLE_LAT;
                    4'd2:    r = ROLE_NS;
                    4'd3:    r = ROLE_LON;
                    4'd4:    r = ROLE_EW;
                    4'd5:    r = ROLE_TIME;
                    default: r = ROLE_NONE;
                endcase
            end
            default: r = ROLE_NONE;
        endcase
        return r;
    endfunction

    // Sentence and field state.
    logic                r_in_sentence, n_in_sentence;
    logic [POS_W-1:0]    r_pos,         n_pos;
    logic [3:0]          r_field,       n_field;
    t_kind               r_kind,        n_kind;
    logic [CHR_W-1:0]    r_chars,       n_chars;
    logic                r_after_point, n_after_point;
    logic                r_num_ended,   n_num_ended;
    logic [FRAC_W-1:0]   r_frac,        n_frac;
    logic [ACC_W-1:0]    r_acc,         n_acc;
    logic [VALUE_W-1:0]  r_pend_time,   n_pend_time;
    logic [VALUE_W-1:0]  r_pend_lat,    n_pend_lat;
    logic [VALUE_W-1:0]  r_pend_lon,    n_pend_lon;
    logic                r_pend_ns,     n_pend_ns;
    logic                r_pend_s,      n_pend_s;
    logic                r_pend_ew,     n_pend_ew;
    logic                r_pend_w,      n_pend_w;
    logic [VALUE_W-1:0]  r_held_lat,    n_held_lat;
    logic [VALUE_W-1:0]  r_held_lon,    n_held_lon;
    logic                r_held_s,      n_held_s;
    logic                r_held_w,      n_held_w;

    // Result register.
    logic                r_out_valid,   n_out_valid;
    logic [1:0]          r_out_type,    n_out_type;
    logic [VALUE_W-1:0]  r_out_time,    n_out_time;
    logic                r_out_upd,     n_out_upd;

    logic                fire;
    logic                emit;
    logic                pos_valid;
    t_role               role;
    logic [MUL_W-1:0]    mul10;
    logic [PROD_W-1:0]   prod;
    logic [VALUE_W-1:0]  scaled;

    // Hold a newline back only while an untaken result sits in the register.
    assign o_pop = i_not_empty &&
                   ((i_token.cls != CLS_NEWLINE) || !r_out_valid || i_ready);
    assign fire  = o_pop;

    // Digit accumulate with saturation.
    assign mul10 = MUL_W'(r_acc) * MUL_W'(10) + MUL_W'(i_token.digit);

    // Scale the finished number by the missing fraction digits.
    assign prod   = PROD_W'(r_acc) * PROD_W'(pow10(3'(FRAC_C - r_frac)));
    assign scaled = (prod[PROD_W-1:VALUE_W] != '0) ? '1 : prod[VALUE_W-1:0];

    always_comb begin
        n_in_sentence = r_in_sentence;
        n_pos         = r_pos;
        n_field       = r_field;
        n_kind        = r_kind;
        n_chars       = r_chars;
        n_after_point = r_after_point;
        n_num_ended   = r_num_ended;
        n_frac        = r_frac;
        n_acc         = r_acc;
        n_pend_time   = r_pend_time;
        n_pend_lat    = r_pend_lat;
        n_pend_lon    = r_pend_lon;
        n_pend_ns     = r_pend_ns;
        n_pend_s      = r_pend_s;
        n_pend_ew     = r_pend_ew;
        n_pend_w      = r_pend_w;
        n_held_lat    = r_held_lat;
        n_held_lon    = r_held_lon;
        n_held_s      = r_held_s;
        n_held_w      = r_held_w;
        n_out_type    = r_out_type;
        n_out_time    = r_out_time;
        n_out_upd     = r_out_upd;
        emit          = 1'b0;
        pos_valid     = 1'b0;
        role          = ROLE_NONE;

        if (fire) begin
            if (i_token.cls == CLS_DOLLAR) begin
                // Start a fresh sentence.
                n_in_sentence = 1'b1;
                n_pos         = POS_W'(1);
                n_field       = '0;
                n_kind        = KIND_NONE;
                n_chars       = '0;
                n_after_point = 1'b0;
                n_num_ended   = 1'b0;
                n_frac        = '0;
                n_acc         = '0;
                n_pend_time   = '0;
                n_pend_lat    = '0;
                n_pend_lon    = '0;
                n_pend_ns     = 1'b0;
                n_pend_s      = 1'b0;
                n_pend_ew     = 1'b0;
                n_pend_w      = 1'b0;
            end else if (r_in_sentence) begin
                if (i_token.cls == CLS_NEWLINE) begin
                    // Close the last field and the sentence.
                    role = role_of(r_kind, r_field);
                    if (role == ROLE_TIME) begin
                        n_pend_time = scaled;
                    end else if (role == ROLE_LAT) begin
                        n_pend_lat = scaled;
                    end else if (role == ROLE_LON) begin
                        n_pend_lon = scaled;
                    end
                    n_chars       = '0;
                    n_after_point = 1'b0;
                    n_num_ended   = 1'b0;
                    n_frac        = '0;
                    n_acc         = '0;
                    n_in_sentence = 1'b0;
                    if (r_kind != KIND_NONE) begin
                        emit      = 1'b1;
                        pos_valid = r_pend_ns && r_pend_ew;
                        if (pos_valid) begin
                            n_held_lat = n_pend_lat;
                            n_held_lon = n_pend_lon;
                            n_held_s   = r_pend_s;
                            n_held_w   = r_pend_w;
                        end
                        n_out_type = 2'(r_kind - KIND_GGA);
                        n_out_time = n_pend_time;
                        n_out_upd  = pos_valid;
                    end
                end else if (r_pos < POS_W'(MAX_SENTENCE_LEN)) begin
                    // Detect the sentence type from the address.
                    if (r_pos == POS_W'(4) && r_kind == KIND_NONE) begin
                        if (i_token.hint == HINT_G) begin
                            n_kind = KIND_GGA;
                        end else if (i_token.hint == HINT_M) begin
                            n_kind = KIND_RMC;
                        end
                    end else if (r_pos == POS_W'(5) && r_kind == KIND_NONE &&
                                 i_token.hint == HINT_L) begin
                        n_kind = KIND_GLL;
                    end
                    n_pos = r_pos + POS_W'(1);
                    role  = role_of(n_kind, r_field);

                    if (i_token.cls == CLS_COMMA) begin
                        // End the field and move to the next.
                        if (role == ROLE_TIME) begin
                            n_pend_time = scaled;
                        end else if (role == ROLE_LAT) begin
                            n_pend_lat = scaled;
                        end else if (role == ROLE_LON) begin
                            n_pend_lon = scaled;
                        end
                        n_chars       = '0;
                        n_after_point = 1'b0;
                        n_num_ended   = 1'b0;
                        n_frac        = '0;
                        n_acc         = '0;
                        if (r_field != 4'd15) begin
                            n_field = r_field + 4'd1;
                        end
                    end else if (r_chars < CHR_W'(MAX_FIELD_LEN)) begin
                        // Take the mark from the first character.
                        if (r_chars == '0) begin
                            if (role == ROLE_NS) begin
                                n_pend_ns = i_token.ns_mark;
                                n_pend_s  = i_token.south;
                            end else if (role == ROLE_EW) begin
                                n_pend_ew = i_token.ew_mark;
                                n_pend_w  = i_token.west;
                            end
                        end
                        // Accumulate the number.
                        if (!r_num_ended) begin
                            if (i_token.cls == CLS_DIGIT) begin
                                if (!r_after_point || r_frac < FRAC_C) begin
                                    n_acc = (mul10 > MUL_MAX) ? ACC_SAT : mul10[ACC_W-1:0];
                                    if (r_after_point) begin
                                        n_frac = r_frac + FRAC_W'(1);
                                    end
                                end
                            end else if (i_token.cls == CLS_POINT && !r_after_point) begin
                                n_after_point = 1'b1;
                            end else begin
                                n_num_ended = 1'b1;
                            end
                        end
                        n_chars = r_chars + CHR_W'(1);
                    end
                end
            end
        end

        // Result register: load on emit, drop once taken.
        if (emit) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_sentence <= 1'b0;
            r_pos         <= '0;
            r_field       <= '0;
            r_kind        <= KIND_NONE;
            r_chars       <= '0;
            r_after_point <= 1'b0;
            r_num_ended   <= 1'b0;
            r_frac        <= '0;
            r_acc         <= '0;
            r_pend_time   <= '0;
            r_pend_lat    <= '0;
            r_pend_lon    <= '0;
            r_pend_ns     <= 1'b0;
            r_pend_s      <= 1'b0;
            r_pend_ew     <= 1'b0;
            r_pend_w      <= 1'b0;
            r_held_lat    <= '0;
            r_held_lon    <= '0;
            r_held_s      <= 1'b0;
            r_held_w      <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_in_sentence <= n_in_sentence;
            r_pos         <= n_pos;
            r_field       <= n_field;
            r_kind        <= n_kind;
            r_chars       <= n_chars;
            r_after_point <= n_after_point;
            r_num_ended   <= n_num_ended;
            r_frac        <= n_frac;
            r_acc         <= n_acc;
            r_pend_time   <= n_pend_time;
            r_pend_lat    <= n_pend_lat;
            r_pend_lon    <= n_pend_lon;
            r_pend_ns     <= n_pend_ns;
            r_pend_s      <= n_pend_s;
            r_pend_ew     <= n_pend_ew;
            r_pend_w      <= n_pend_w;
            r_held_lat    <= n_held_lat;
            r_held_lon    <= n_held_lon;
            r_held_s      <= n_held_s;
            r_held_w      <= n_held_w;
            r_out_valid   <= n_out_valid;
        end
    end

    // Result payload needs no reset.
    always_ff @(posedge i_clk) begin
        r_out_type <= n_out_type;
        r_out_time <= n_out_time;
        r_out_upd  <= n_out_upd;
    end

    assign o_valid            = r_out_valid;
    assign o_sentence_type    = r_out_type;
    assign o_utc_time         = r_out_time;
    assign o_latitude         = r_held_lat;
    assign o_south            = r_held_s;
    assign o_longitude        = r_held_lon;
    assign o_west             = r_held_w;
    assign o_position_updated = r_out_upd;

endmodule

### rtl/nmea_position_parser.sv
// NMEA position parser top level: input stage, byte queue and parser.
`timescale 1ns / 1ps

// Parses a stream of NMEA 0183 characters, one byte per transaction, and
// recognizes GGA, RMC and GLL sentences. Each newline that ends a known
// sentence produces one result: the sentence type, the UTC time and the
// held position, which is replaced only when both hemisphere marks of the
// sentence are valid. Numbers are decimal fixed point scaled by ten to
// FRAC_DIGITS, saturating at the top of 32 bits. The block takes one byte
// per clock cycle while the queue has room. A byte passes the combinational
// classifier into a QUEUE_DEPTH entry queue, and the parser takes it from
// the queue head once it is stored there. A result is loaded into the
// output register when the parser takes the newline that ends it. The
// parser consumes one byte per cycle and pauses only on a newline while the
// previous result still waits in the output register; input stalls once the
// queue is full. QUEUE_DEPTH must be two or more.

module nmea_position_parser
    import nmea_pkg::*;
#(
    parameter int MAX_SENTENCE_LEN = 80,
    parameter int MAX_FIELD_LEN    = 20,
    parameter int FRAC_DIGITS      = 4,
    parameter int QUEUE_DEPTH      = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [7:0]          i_rx_byte,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [1:0]          o_sentence_type,
    output logic [VALUE_W-1:0]  o_utc_time,
    output logic [VALUE_W-1:0]  o_latitude,
    output logic                o_south,
    output logic [VALUE_W-1:0]  o_longitude,
    output logic                o_west,
    output logic                o_position_updated
);

    logic   queue_full;
    logic   queue_not_empty;
    logic   push;
    logic   pop;
    t_token push_token;
    t_token head_token;

    // Classify incoming bytes.
    nmea_front u_front (
        .i_valid      (i_valid),
        .i_rx_byte    (i_rx_byte),
        .i_queue_full (queue_full),
        .o_ready      (o_ready),
        .o_push       (push),
        .o_token      (push_token)
    );

    // Decouple input from parser.
    nmea_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_token     (push_token),
        .i_pop       (pop),
        .o_full      (queue_full),
        .o_not_empty (queue_not_empty),
        .o_token     (head_token)
    );

    // Parse sentences and deliver results.
    nmea_back #(
        .MAX_SENTENCE_LEN (MAX_SENTENCE_LEN),
        .MAX_FIELD_LEN    (MAX_FIELD_LEN),
        .FRAC_DIGITS      (FRAC_DIGITS)
    ) u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_not_empty        (queue_not_empty),
        .i_token            (head_token),
        .o_pop              (pop),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_sentence_type    (o_sentence_type),
        .o_utc_time         (o_utc_time),
        .o_latitude         (o_latitude),
        .o_south            (o_south),
        .o_longitude        (o_longitude),
        .o_west             (o_west),
        .o_position_updated (o_position_updated)
    );

endmodule

### test/nmea_fix_checker.sv
// Checker for the NMEA position parser: predicts every fix and compares results.
`timescale 1ns / 1ps

module nmea_fix_checker
    import nmea_pkg::*;
#(
    parameter int MAX_SENTENCE_LEN = 80,
    parameter int MAX_FIELD_LEN    = 20,
    parameter int FRAC_DIGITS      = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_rx_valid,
    input  logic               i_rx_ready,
    input  logic [7:0]         i_rx_byte,
    input  logic               i_fix_valid,
    input  logic               i_fix_ready,
    input  logic [1:0]         i_sentence_type,
    input  logic [VALUE_W-1:0] i_utc_time,
    input  logic [VALUE_W-1:0] i_latitude,
    input  logic               i_south,
    input  logic [VALUE_W-1:0] i_longitude,
    input  logic               i_west,
    input  logic               i_position_updated,
    output int                 o_fail_count,
    output int                 o_pending
);

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_GGA,
        KIND_RMC,
        KIND_GLL
    } t_kind;

    typedef enum logic [1:0] {
        SENT_GGA,
        SENT_RMC,
        SENT_GLL
    } t_sentence;

    typedef enum logic [2:0] {
        ROLE_NONE,
        ROLE_TIME,
        ROLE_LAT,
        ROLE_NS,
        ROLE_LON,
        ROLE_EW
    } t_role;

    typedef struct packed {
        logic [1:0]         stype;
        logic [VALUE_W-1:0] utc;
        logic [VALUE_W-1:0] lat;
        logic               south;
        logic [VALUE_W-1:0] lon;
        logic               west;
        logic               updated;
    } t_fix;

    localparam logic [ACC_W-1:0] ACC_SAT   = 33'h1_0000_0000;
    localparam logic [63:0]      VALUE_MAX = 64'hFFFF_FFFF;

    // Parser state as predicted
    logic               in_sent;
    logic [6:0]         char_pos;
    logic [3:0]         field_idx;
    t_kind              kind;
    logic [4:0]         field_chars;
    logic               seen_point;
    logic               num_done;
    logic [2:0]         frac_cnt;
    logic [ACC_W-1:0]   acc;
    logic [VALUE_W-1:0] pend_time;
    logic [VALUE_W-1:0] pend_lat;
    logic [VALUE_W-1:0] pend_lon;
    logic [7:0]         pend_ns;
    logic [7:0]         pend_ew;
    logic [VALUE_W-1:0] held_lat;
    logic [VALUE_W-1:0] held_lon;
    logic               held_south;
    logic               held_west;

    t_fix expected_fixes[$];
    t_fix new_fix;
    t_fix want;
    logic got_fix;
    int   fails = 0;

    // Meaning of the field in progress for the sentence type found so far
    function automatic t_role field_role();
        t_role r;
        r = ROLE_NONE;
        case (kind)
            KIND_GGA: begin
                case (field_idx)
                    4'd1:    r = ROLE_TIME;
                    4'd2:    r = ROLE_LAT;
                    4'd3:    r = ROLE_NS;
                    4'd4:    r = ROLE_LON;
                    4'd5:    r = ROLE_EW;
                    default: r = ROLE_NONE;
                endcase
            end
            KIND_RMC: begin
                case (field_idx)
                    4'd1:    r = ROLE_TIME;
                    4'd3:    r = ROLE_LAT;
                    4'd4:    r = ROLE_NS;
                    4'd5:    r = ROLE_LON;
                    4'd6:    r = ROLE_EW;
                    default: r = ROLE_NONE;
                endcase
            end
            KIND_GLL: begin
                case (field_idx)
                    4'd1:    r = ROLE_LAT;
                    4'd2:    r = ROLE_NS;
                    4'd3:    r = ROLE_LON;
                    4'd4:    r = ROLE_EW;
                    4'd5:    r = ROLE_TIME;
                    default: r = ROLE_NONE;
                endcase
            end
            default: r = ROLE_NONE;
        endcase
        return r;
    endfunction

    // Scale the accumulated digits up to FRAC_DIGITS places, saturating
    function automatic logic [VALUE_W-1:0] scaled_value();
        logic [63:0] v;
        int          fc;
        fc = (int'(frac_cnt) > FRAC_DIGITS) ? FRAC_DIGITS : int'(frac_cnt);
        v  = {31'd0, acc};
        for (int k = fc; k < FRAC_DIGITS; k++) begin
            v = v * 10;
        end
        return (v > VALUE_MAX) ? '1 : v[VALUE_W-1:0];
    endfunction

    task automatic clear_number();
        field_chars = '0;
        seen_point  = 1'b0;
        num_done    = 1'b0;
        frac_cnt    = '0;
        acc         = '0;
    endtask

    task automatic clear_pending();
        pend_time = '0;
        pend_lat  = '0;
        pend_lon  = '0;
        pend_ns   = '0;
        pend_ew   = '0;
    endtask

    // Store the finished field where its role says, then start a new one
    task automatic end_field();
        case (field_role())
            ROLE_TIME: pend_time = scaled_value();
            ROLE_LAT:  pend_lat  = scaled_value();
            ROLE_LON:  pend_lon  = scaled_value();
            default:   ;
        endcase
        clear_number();
    endtask

    task automatic add_digit(input logic [3:0] d);
        logic [63:0] t;
        t   = {31'd0, acc} * 10 + 64'(d);
        acc = (t > VALUE_MAX) ? ACC_SAT : t[ACC_W-1:0];
    endtask

    // Take one character of a field: capture marks, accumulate the number
    task automatic field_char(input logic [7:0] c);
        t_role r;
        if (int'(field_chars) < MAX_FIELD_LEN) begin
            r = field_role();
            if (field_chars == 0) begin
                if (r == ROLE_NS) pend_ns = c;
                else if (r == ROLE_EW) pend_ew = c;
            end
            if (!num_done) begin
                if (c >= CH_ZERO && c <= CH_NINE) begin
                    if (!seen_point) begin
                        add_digit(4'(c - CH_ZERO));
                    end else if (int'(frac_cnt) < FRAC_DIGITS) begin
                        add_digit(4'(c - CH_ZERO));
                        frac_cnt++;
                    end
                end else if (c == CH_POINT && !seen_point) begin
                    seen_point = 1'b1;
                end else begin
                    num_done = 1'b1;
                end
            end
            field_chars++;
        end
    endtask

    task automatic reset_parser();
        in_sent    = 1'b0;
        char_pos   = '0;
        field_idx  = '0;
        kind       = KIND_NONE;
        clear_number();
        clear_pending();
        held_lat   = '0;
        held_lon   = '0;
        held_south = 1'b0;
        held_west  = 1'b0;
    endtask

    // Advance the parser by one received byte; report a fix on a closing newline
    task automatic parse_byte(input logic [7:0] c, output logic got, output t_fix f);
        logic marks_ok;
        got = 1'b0;
        f   = '0;
        if (c == CH_DOLLAR) begin
            in_sent   = 1'b1;
            char_pos  = 7'd1;
            field_idx = '0;
            kind      = KIND_NONE;
            clear_number();
            clear_pending();
        end else if (in_sent) begin
            if (c == CH_NEWLINE) begin
                end_field();
                in_sent = 1'b0;
                if (kind != KIND_NONE) begin
                    marks_ok = (pend_ns == CH_N || pend_ns == CH_S) &&
                               (pend_ew == CH_E || pend_ew == CH_W);
                    if (marks_ok) begin
                        held_lat   = pend_lat;
                        held_lon   = pend_lon;
                        held_south = (pend_ns == CH_S);
                        held_west  = (pend_ew == CH_W);
                    end
                    case (kind)
                        KIND_GGA: f.stype = SENT_GGA;
                        KIND_RMC: f.stype = SENT_RMC;
                        default:  f.stype = SENT_GLL;
                    endcase
                    f.utc     = pend_time;
                    f.lat     = held_lat;
                    f.south   = held_south;
                    f.lon     = held_lon;
                    f.west    = held_west;
                    f.updated = marks_ok;
                    got       = 1'b1;
                end
            end else if (int'(char_pos) < MAX_SENTENCE_LEN) begin
                // Pick the sentence type from the address letters
                if (char_pos == 7'd4 && kind == KIND_NONE) begin
                    if (c == CH_G) kind = KIND_GGA;
                    else if (c == CH_M) kind = KIND_RMC;
                end else if (char_pos == 7'd5 && kind == KIND_NONE && c == CH_L) begin
                    kind = KIND_GLL;
                end
                char_pos++;
                if (c == CH_COMMA) begin
                    end_field();
                    if (field_idx < 4'd15) field_idx++;
                end else begin
                    field_char(c);
                end
            end
        end
    endtask

    task automatic check_field(input string name, input logic [VALUE_W-1:0] exp_val,
                               input logic [VALUE_W-1:0] act_val);
        if (exp_val !== act_val) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, name, exp_val, act_val);
            fails++;
        end
    endtask

    // Predict on each accepted byte, compare on each accepted result
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_parser();
            expected_fixes.delete();
        end else begin
            if (i_rx_valid && i_rx_ready) begin
                parse_byte(i_rx_byte, got_fix, new_fix);
                if (got_fix) expected_fixes.push_back(new_fix);
            end
            if (i_fix_valid && i_fix_ready) begin
                if (expected_fixes.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual type %0d time %0d",
                             $time, i_sentence_type, i_utc_time);
                    fails++;
                end else begin
                    want = expected_fixes.pop_front();
                    check_field("sentence_type", 32'(want.stype), 32'(i_sentence_type));
                    check_field("utc_time", want.utc, i_utc_time);
                    check_field("latitude", want.lat, i_latitude);
                    check_field("south", 32'(want.south), 32'(i_south));
                    check_field("longitude", want.lon, i_longitude);
                    check_field("west", 32'(want.west), 32'(i_west));
                    check_field("position_updated", 32'(want.updated),
                                32'(i_position_updated));
                end
            end
        end
        o_pending    <= expected_fixes.size();
        o_fail_count <= fails;
    end

endmodule

### test/nmea_position_parser_tb.sv
// Testbench top for the NMEA position parser: sentence stimulus and verdict.
`timescale 1ns / 1ps

module nmea_position_parser_tb
    import nmea_pkg::*;
();

    localparam int MAX_SENTENCE_LEN = 80;
    localparam int MAX_FIELD_LEN    = 20;
    localparam int FRAC_DIGITS      = 4;
    localparam int SETTLE_CYCLES    = 16;
    localparam int PHASE_BYTES      = 450;
    localparam int PHASE_SENTENCES  = 6;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic [7:0]         i_rx_byte;
    logic               o_valid;
    logic               i_ready;
    logic [1:0]         o_sentence_type;
    logic [VALUE_W-1:0] o_utc_time;
    logic [VALUE_W-1:0] o_latitude;
    logic               o_south;
    logic [VALUE_W-1:0] o_longitude;
    logic               o_west;
    logic               o_position_updated;

    int         fail_count;
    int         fixes_pending;
    bit         no_idle = 1'b0;
    int         bytes_sent = 0;
    int         sentences_made = 0;
    logic [7:0] sentence_q[$];

    nmea_position_parser #(
        .MAX_SENTENCE_LEN(MAX_SENTENCE_LEN),
        .MAX_FIELD_LEN   (MAX_FIELD_LEN),
        .FRAC_DIGITS     (FRAC_DIGITS)
    ) dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_rx_byte         (i_rx_byte),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_sentence_type   (o_sentence_type),
        .o_utc_time        (o_utc_time),
        .o_latitude        (o_latitude),
        .o_south           (o_south),
        .o_longitude       (o_longitude),
        .o_west            (o_west),
        .o_position_updated(o_position_updated)
    );

    nmea_fix_checker #(
        .MAX_SENTENCE_LEN(MAX_SENTENCE_LEN),
        .MAX_FIELD_LEN   (MAX_FIELD_LEN),
        .FRAC_DIGITS     (FRAC_DIGITS)
    ) u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_rx_valid        (i_valid),
        .i_rx_ready        (o_ready),
        .i_rx_byte         (i_rx_byte),
        .i_fix_valid       (o_valid),
        .i_fix_ready       (i_ready),
        .i_sentence_type   (o_sentence_type),
        .i_utc_time        (o_utc_time),
        .i_latitude        (o_latitude),
        .i_south           (o_south),
        .i_longitude       (o_longitude),
        .i_west            (o_west),
        .i_position_updated(o_position_updated),
        .o_fail_count      (fail_count),
        .o_pending         (fixes_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case a result never arrives
    initial begin
        #10_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Result side: stall a random number of cycles before each transaction
    initial begin : fix_receiver
        int stall;
        i_ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = (no_idle || $urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 17);
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
        end
    end

    // Present one byte after a random gap and hold it until accepted
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = (no_idle || $urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int k = 0; k < s.len(); k++) send_byte(s[k]);
    endtask

    // Hold off the sender until every predicted fix has come out
    task automatic wait_for_fixes();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (fixes_pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic push_text(input string s);
        for (int k = 0; k < s.len(); k++) sentence_q.push_back(s[k]);
    endtask

    function automatic logic [7:0] printable_char();
        logic [7:0] c;
        c = 8'($urandom_range(33, 126));
        return (c == CH_DOLLAR) ? CH_POINT : c;
    endfunction

    // Number field: optional sign or space, digits, optional point and fraction, sometimes a stray character
    task automatic push_number();
        int n_int;
        int n_frac;
        case ($urandom_range(0, 11))
            0:       push_text("-");
            1:       push_text(" ");
            default: ;
        endcase
        n_int = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 13) : $urandom_range(0, 6);
        for (int k = 0; k < n_int; k++) sentence_q.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
        if ($urandom_range(0, 3) != 0) begin
            sentence_q.push_back(CH_POINT);
            n_frac = $urandom_range(0, 7);
            for (int k = 0; k < n_frac; k++) begin
                sentence_q.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
            end
        end
        if ($urandom_range(0, 11) == 0) sentence_q.push_back(printable_char());
    endtask

    // Mark field: mostly one of the two valid letters, sometimes empty, wrong or followed by a stray character
    task automatic push_mark(input logic [7:0] mark_a, input logic [7:0] mark_b);
        case ($urandom_range(0, 9))
            0:       ;
            1:       sentence_q.push_back(8'($urandom_range(65, 90)));
            2:       sentence_q.push_back(printable_char());
            default: sentence_q.push_back($urandom_range(0, 1) ? mark_a : mark_b);
        endcase
        if ($urandom_range(0, 7) == 0) sentence_q.push_back(printable_char());
    endtask

    task automatic push_other_field();
        int len;
        len = ($urandom_range(0, 15) == 0) ? $urandom_range(21, 30) : $urandom_range(0, 4);
        for (int k = 0; k < len; k++) begin
            sentence_q.push_back(($urandom_range(0, 1) == 0) ?
                                 8'(CH_ZERO + $urandom_range(0, 9)) : printable_char());
        end
    endtask

    // Build one sentence with random content, now and then broken or padded
    task automatic make_sentence();
        string layout;
        int    n_extra;
        sentence_q.delete();
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 3)) sentence_q.push_back(8'($urandom_range(0, 255)));
        end
        push_text("$");
        sentence_q.push_back(($urandom_range(0, 2) == 0) ? 8'($urandom_range(65, 90)) : CH_G);
        sentence_q.push_back(($urandom_range(0, 2) == 0) ? 8'($urandom_range(65, 90)) : 8'h50);
        case ($urandom_range(0, 9))
            0, 1, 2: begin
                push_text("GGA");
                layout = "tanoex";
            end
            3, 4, 5: begin
                push_text("RMC");
                layout = "txanoe";
            end
            6, 7, 8: begin
                push_text("GLL");
                layout = "anoetx";
            end
            default: begin
                repeat (3) sentence_q.push_back(8'($urandom_range(65, 90)));
                layout = "tanoe";
            end
        endcase
        for (int k = 0; k < layout.len(); k++) begin
            sentence_q.push_back(CH_COMMA);
            case (layout[k])
                "t", "a", "o": push_number();
                "n":           push_mark(CH_N, CH_S);
                "e":           push_mark(CH_E, CH_W);
                default:       push_other_field();
            endcase
        end
        // Pad past the field limit and the sentence length now and then
        if ($urandom_range(0, 11) == 0) begin
            n_extra = $urandom_range(8, 20);
            for (int k = 0; k < n_extra; k++) begin
                sentence_q.push_back(CH_COMMA);
                push_other_field();
            end
        end
        case ($urandom_range(0, 15))
            0: ;
            1: begin
                sentence_q.insert($urandom_range(1, sentence_q.size() - 1),
                                  8'($urandom_range(0, 255)));
                sentence_q.push_back(CH_NEWLINE);
            end
            default: begin
                sentence_q.push_back(CH_NEWLINE);
                sentences_made++;
            end
        endcase
    endtask

    initial begin : stimulus
        i_rst_n   <= 1'b0;
        i_valid   <= 1'b0;
        i_rx_byte <= 8'h00;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Bytes and a newline outside any sentence
        send_text("junk\n");
        send_byte(8'hFF);
        // Plain sentences of each type, saturation and an invalid mark
        send_text("$GPGGA,235959.999,4916.45,N,12311.12,W\n");
        send_text("$GNRMC,1,A,99999999999,S,4294967295,E\n");
        send_text("$GPGLL,0.00001,X,2.5,E,12\n");
        // Unknown type, restart inside a sentence with empty fields
        send_text("$GPVTG,1,N,2,E\n");
        send_text("$GP$GPGGA,,,,,\n");
        // Type found only after the first field has ended
        send_text("$,1,G5,N,7,E\n");
        // Sign, leading space and a second point
        send_text("$GPGGA,-5, 12,N,3.2.1,E\n");
        // Overlong field, then field count and sentence length past their limits
        send_text("$GPGLL,123456789012345678901234,S,1,W\n");
        send_text("$GPGGA,1,2,N,3,E");
        repeat (70) send_byte(CH_COMMA);
        send_text("9\n");
        wait_for_fixes();

        // Random sentences; the middle phase runs without idling
        for (int phase = 0; phase < 3; phase++) begin
            no_idle = (phase == 1);
            while (bytes_sent < PHASE_BYTES * (phase + 1) ||
                   sentences_made < PHASE_SENTENCES * (phase + 1)) begin
                make_sentence();
                foreach (sentence_q[k]) send_byte(sentence_q[k]);
            end
            wait_for_fixes();
        end

        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
